// ===== sv/ldp_pkg.sv =====
// ----------------------------------------------------------------------------
// ldp_pkg: shared definitions for the lens distortion projection core
// Register indexes, fixed-point constants, pipeline depth and output limits.
// ----------------------------------------------------------------------------
package ldp_pkg;

	// number of register stages from input to result
	localparam int unsigned NumStages = 16;

	// register indexes on the configuration port
	typedef enum logic [3:0] {
		RegFocalX     = 4'd0,
		RegFocalY     = 4'd1,
		RegCenterX    = 4'd2,
		RegCenterY    = 4'd3,
		RegRadialK1   = 4'd4,
		RegRadialK2   = 4'd5,
		RegRadialK3   = 4'd6,
		RegTangential = 4'd7
	} cfg_idx_t;

	// fraction bits of the geometric values and of the coefficients
	localparam int unsigned FracQ28 = 28;
	localparam int unsigned FracQ24 = 24;

	// rounding offsets (half an lsb of the shifted result) and 1.0 in Q.28
	localparam logic [63:0] HalfQ28 = 64'd1 << (FracQ28 - 1);
	localparam logic [63:0] HalfQ24 = 64'd1 << (FracQ24 - 1);
	localparam logic [63:0] OneQ28  = 64'd1 << FracQ28;

	// register reset values
	localparam logic [31:0] FocalReset = 32'd65536;

	// output clamp limits
	localparam logic signed [31:0] PixMax = 32'sh7fff_ffff;
	localparam logic signed [31:0] PixMin = 32'sh8000_0000;

endpackage

// ===== sv/lens_distortion_projection_core.sv =====
// ----------------------------------------------------------------------------
// lens_distortion_projection_core: Brown-Conrady 5-coefficient projection
// Maps a normalized point (Q3.28) to a distorted pixel position (Q16.16)
// with three radial terms, two tangential terms, focal scale and center.
// ----------------------------------------------------------------------------
//
// channel   signals                                   role
// point     point_valid point_stall norm_x norm_y     item in, Q3.28 point
// result    result_valid result_stall pixel_x         item out, Q16.16 pixel
//           pixel_y saturated
// cfg       cfg_valid cfg_ready cfg_index cfg_data    register write, always ready
//
// one item per clock while the result side does not stall; the pipeline depth is set
// by the dependent multiply chain r2 -> r4 -> r6 -> k3 term -> x*rc -> focal,
// each multiply split into a partial-product stage and a sum-and-round stage.
// reset empties the pipeline and loads the register reset values.
// a stall on the result side holds only the stages behind the waiting result;
// earlier stages keep filling empty slots, so bubbles squeeze out.
module lens_distortion_projection_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               point_valid,
	output logic               point_stall,
	input  logic signed [31:0] norm_x,
	input  logic signed [31:0] norm_y,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] pixel_x,
	output logic signed [31:0] pixel_y,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	// configuration registers
	logic [31:0]        focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic signed [31:0] k1_q, k2_q, k3_q;
	logic [63:0]        tang_q;
	logic signed [31:0] p1, p2;

	// pipeline control
	logic [ldp_pkg::NumStages-1:0] vld_q;
	logic [ldp_pkg::NumStages-1:0] en;

	// stage 1: squares and cross product
	logic signed [63:0] pxx_s1, pyy_s1, pxy_s1;
	logic signed [31:0] x_s1, y_s1;
	// stage 2
	logic [63:0]        rxx, ryy, rxy;
	logic [34:0]        xx_s2, yy_s2;
	logic signed [35:0] xy_s2;
	logic signed [31:0] x_s2, y_s2;
	// stage 3
	logic [35:0]        r2_s3;
	logic [34:0]        xx_s3, yy_s3;
	logic signed [35:0] xy_s3;
	logic signed [31:0] x_s3, y_s3;
	// stage 4
	logic [17:0]        rl3, rh3, xyl3;
	logic signed [17:0] xyh3;
	logic [35:0]        mhh_s4, mhl_s4, mll_s4;
	logic signed [50:0] k1l_s4, k1h_s4;
	logic signed [50:0] a1l_s4, a2l_s4;
	logic signed [49:0] a1h_s4, a2h_s4;
	logic               na1_s4, na2_s4;
	logic [36:0]        tx_s4, ty_s4;
	logic [35:0]        r2_s4;
	logic signed [31:0] x_s4, y_s4;
	// stage 5
	logic [71:0]        sr4;
	logic [67:0]        sk1;
	logic [66:0]        sa1, sa2;
	logic [18:0]        txl4, tyl4;
	logic [17:0]        txh4, tyh4;
	logic [42:0]        r4_s5;
	logic signed [43:0] k1r2_s5;
	logic signed [42:0] t1_s5, t2_s5;
	logic signed [51:0] b2l_s5, b1l_s5;
	logic signed [50:0] b2h_s5, b1h_s5;
	logic [35:0]        r2_s5;
	logic signed [31:0] x_s5, y_s5;
	// stage 6
	logic [21:0]        r4l5;
	logic [20:0]        r4h5;
	logic [17:0]        rl5, rh5;
	logic [68:0]        sux, suy;
	logic [39:0]        qll_s6, qlh_s6;
	logic [38:0]        qhl_s6, qhh_s6;
	logic signed [54:0] c2l_s6;
	logic signed [53:0] c2h_s6;
	logic signed [44:0] ux_s6, uy_s6;
	logic signed [43:0] rc1_s6;
	logic signed [42:0] t1_s6, t2_s6;
	logic signed [31:0] x_s6, y_s6;
	// stage 7
	logic [77:0]        sr6;
	logic [74:0]        sk2;
	logic [49:0]        r6_s7;
	logic signed [50:0] k2r4_s7;
	logic signed [45:0] tanx_s7, tany_s7;
	logic signed [43:0] rc1_s7;
	logic signed [31:0] x_s7, y_s7;
	// stage 8
	logic [24:0]        r6l7, r6h7;
	logic signed [57:0] d3l_s8, d3h_s8;
	logic signed [50:0] rc2_s8;
	logic signed [45:0] tanx_s8, tany_s8;
	logic signed [31:0] x_s8, y_s8;
	// stage 9
	logic [81:0]        sk3;
	logic signed [57:0] k3r6_s9;
	logic signed [50:0] rc2_s9;
	logic signed [45:0] tanx_s9, tany_s9;
	logic signed [31:0] x_s9, y_s9;
	// stage 10
	logic signed [57:0] rc_s10;
	logic signed [45:0] tanx_s10, tany_s10;
	logic signed [31:0] x_s10, y_s10;
	// stage 11
	logic [28:0]        rcl10;
	logic signed [28:0] rch10;
	logic signed [61:0] exl_s11, eyl_s11;
	logic signed [60:0] exh_s11, eyh_s11;
	logic               nex_s11, ney_s11;
	logic signed [45:0] tanx_s11, tany_s11;
	// stage 12
	logic [89:0]        sxd, syd;
	logic signed [60:0] xd0_s12, yd0_s12;
	logic signed [45:0] tanx_s12, tany_s12;
	// stage 13
	logic signed [60:0] xd_s13, yd_s13;
	// stage 14
	logic [30:0]        xdl13, ydl13;
	logic signed [29:0] xdh13, ydh13;
	logic signed [64:0] fxl_s14, fyl_s14;
	logic signed [62:0] fxh_s14, fyh_s14;
	logic               nfx_s14, nfy_s14;
	// stage 15
	logic [92:0]        sfx, sfy;
	logic signed [64:0] fmx_s15, fmy_s15;
	// stage 16
	logic signed [65:0] vx, vy;
	logic               ovx, unx, ovy, uny;
	logic signed [31:0] pixel_x_s16, pixel_y_s16;
	logic               sat_s16;

	assign p1 = tang_q[31:0];
	assign p2 = tang_q[63:32];

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= ldp_pkg::FocalReset;
			focal_y_q  <= ldp_pkg::FocalReset;
			center_x_q <= '0;
			center_y_q <= '0;
			k1_q       <= '0;
			k2_q       <= '0;
			k3_q       <= '0;
			tang_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ldp_pkg::cfg_idx_t'(cfg_index))
				ldp_pkg::RegFocalX:     focal_x_q  <= cfg_data[31:0];
				ldp_pkg::RegFocalY:     focal_y_q  <= cfg_data[31:0];
				ldp_pkg::RegCenterX:    center_x_q <= cfg_data[31:0];
				ldp_pkg::RegCenterY:    center_y_q <= cfg_data[31:0];
				ldp_pkg::RegRadialK1:   k1_q       <= cfg_data[31:0];
				ldp_pkg::RegRadialK2:   k2_q       <= cfg_data[31:0];
				ldp_pkg::RegRadialK3:   k3_q       <= cfg_data[31:0];
				ldp_pkg::RegTangential: tang_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- control
	// a stage loads when it is empty or the stage after it moves on
	always_comb begin
		en[ldp_pkg::NumStages-1] = !vld_q[ldp_pkg::NumStages-1] || !result_stall;
		for (int i = ldp_pkg::NumStages - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & {vld_q[ldp_pkg::NumStages-2:0], point_valid}) | (~en & vld_q);
		end
	end

	assign point_stall  = !en[0];
	assign result_valid = vld_q[ldp_pkg::NumStages-1];

	// ---------------------------------------------------------------- datapath
	// rounding: (p + half - neg) >> s gives magnitude rounding half away from zero
	assign rxx = pxx_s1 + ldp_pkg::HalfQ28;
	assign ryy = pyy_s1 + ldp_pkg::HalfQ28;
	assign rxy = pxy_s1 + ldp_pkg::HalfQ28 - 64'(x_s1[31] ^ y_s1[31]);

	assign rl3  = r2_s3[17:0];
	assign rh3  = r2_s3[35:18];
	assign xyl3 = xy_s3[17:0];
	assign xyh3 = xy_s3[35:18];

	assign sr4 = (72'(mhh_s4) << 36) + (72'(mhl_s4) << 19) + 72'(mll_s4)
		+ 72'(ldp_pkg::HalfQ28);
	assign sk1 = (68'(k1h_s4) << 18) + 68'(k1l_s4) + 68'(ldp_pkg::HalfQ24)
		- 68'(k1_q[31]);
	assign sa1 = (67'(a1h_s4) << 18) + 67'(a1l_s4) + 67'(ldp_pkg::HalfQ24) - 67'(na1_s4);
	assign sa2 = (67'(a2h_s4) << 18) + 67'(a2l_s4) + 67'(ldp_pkg::HalfQ24) - 67'(na2_s4);
	assign txl4 = tx_s4[18:0];
	assign txh4 = tx_s4[36:19];
	assign tyl4 = ty_s4[18:0];
	assign tyh4 = ty_s4[36:19];

	assign r4l5 = r4_s5[21:0];
	assign r4h5 = r4_s5[42:22];
	assign rl5  = r2_s5[17:0];
	assign rh5  = r2_s5[35:18];
	assign sux  = (69'(b2h_s5) << 19) + 69'(b2l_s5) + 69'(ldp_pkg::HalfQ24) - 69'(p2[31]);
	assign suy  = (69'(b1h_s5) << 19) + 69'(b1l_s5) + 69'(ldp_pkg::HalfQ24) - 69'(p1[31]);

	assign sr6 = (78'(qhh_s6) << 40) + (78'(qhl_s6) << 22) + (78'(qlh_s6) << 18)
		+ 78'(qll_s6) + 78'(ldp_pkg::HalfQ28);
	assign sk2 = (75'(c2h_s6) << 22) + 75'(c2l_s6) + 75'(ldp_pkg::HalfQ24)
		- 75'(k2_q[31]);

	assign r6l7 = r6_s7[24:0];
	assign r6h7 = r6_s7[49:25];

	assign sk3 = (82'(d3h_s8) << 25) + 82'(d3l_s8) + 82'(ldp_pkg::HalfQ24)
		- 82'(k3_q[31]);

	assign rcl10 = rc_s10[28:0];
	assign rch10 = rc_s10[57:29];

	assign sxd = (90'(exh_s11) << 29) + 90'(exl_s11) + 90'(ldp_pkg::HalfQ28) - 90'(nex_s11);
	assign syd = (90'(eyh_s11) << 29) + 90'(eyl_s11) + 90'(ldp_pkg::HalfQ28) - 90'(ney_s11);

	assign xdl13 = xd_s13[30:0];
	assign xdh13 = xd_s13[60:31];
	assign ydl13 = yd_s13[30:0];
	assign ydh13 = yd_s13[60:31];

	assign sfx = (93'(fxh_s14) << 31) + 93'(fxl_s14) + 93'(ldp_pkg::HalfQ28) - 93'(nfx_s14);
	assign sfy = (93'(fyh_s14) << 31) + 93'(fyl_s14) + 93'(ldp_pkg::HalfQ28) - 93'(nfy_s14);

	assign vx  = 66'(fmx_s15) + 66'(center_x_q);
	assign vy  = 66'(fmy_s15) + 66'(center_y_q);
	assign ovx = vx > 66'(ldp_pkg::PixMax);
	assign unx = vx < 66'(ldp_pkg::PixMin);
	assign ovy = vy > 66'(ldp_pkg::PixMax);
	assign uny = vy < 66'(ldp_pkg::PixMin);

	always_ff @(posedge clk) begin
		// stage 1
		if (en[0]) begin
			pxx_s1 <= 64'(norm_x) * 64'(norm_x);
			pyy_s1 <= 64'(norm_y) * 64'(norm_y);
			pxy_s1 <= 64'(norm_x) * 64'(norm_y);
			x_s1   <= norm_x;
			y_s1   <= norm_y;
		end
		// stage 2
		if (en[1]) begin
			xx_s2 <= rxx[62:28];
			yy_s2 <= ryy[62:28];
			xy_s2 <= rxy[63:28];
			x_s2  <= x_s1;
			y_s2  <= y_s1;
		end
		// stage 3
		if (en[2]) begin
			r2_s3 <= 36'(xx_s2) + 36'(yy_s2);
			xx_s3 <= xx_s2;
			yy_s3 <= yy_s2;
			xy_s3 <= xy_s2;
			x_s3  <= x_s2;
			y_s3  <= y_s2;
		end
		// stage 4: partial products on r2 and xy
		if (en[3]) begin
			mhh_s4 <= 36'(rh3) * 36'(rh3);
			mhl_s4 <= 36'(rh3) * 36'(rl3);
			mll_s4 <= 36'(rl3) * 36'(rl3);
			k1l_s4 <= 51'(k1_q) * 51'(signed'({1'b0, rl3}));
			k1h_s4 <= 51'(k1_q) * 51'(signed'({1'b0, rh3}));
			a1l_s4 <= 51'(p1) * 51'(signed'({1'b0, xyl3}));
			a1h_s4 <= 50'(p1) * 50'(xyh3);
			a2l_s4 <= 51'(p2) * 51'(signed'({1'b0, xyl3}));
			a2h_s4 <= 50'(p2) * 50'(xyh3);
			na1_s4 <= p1[31] ^ xy_s3[35];
			na2_s4 <= p2[31] ^ xy_s3[35];
			tx_s4  <= 37'(r2_s3) + 37'({xx_s3, 1'b0});
			ty_s4  <= 37'(r2_s3) + 37'({yy_s3, 1'b0});
			r2_s4  <= r2_s3;
			x_s4   <= x_s3;
			y_s4   <= y_s3;
		end
		// stage 5: r4, k1 term, tangential products
		if (en[4]) begin
			r4_s5   <= sr4[70:28];
			k1r2_s5 <= sk1[67:24];
			t1_s5   <= sa1[66:24];
			t2_s5   <= sa2[66:24];
			b2l_s5  <= 52'(p2) * 52'(signed'({1'b0, txl4}));
			b2h_s5  <= 51'(p2) * 51'(signed'({1'b0, txh4}));
			b1l_s5  <= 52'(p1) * 52'(signed'({1'b0, tyl4}));
			b1h_s5  <= 51'(p1) * 51'(signed'({1'b0, tyh4}));
			r2_s5   <= r2_s4;
			x_s5    <= x_s4;
			y_s5    <= y_s4;
		end
		// stage 6: partial products of r6 and of the k2 term
		if (en[5]) begin
			qll_s6 <= 40'(r4l5) * 40'(rl5);
			qlh_s6 <= 40'(r4l5) * 40'(rh5);
			qhl_s6 <= 39'(r4h5) * 39'(rl5);
			qhh_s6 <= 39'(r4h5) * 39'(rh5);
			c2l_s6 <= 55'(k2_q) * 55'(signed'({1'b0, r4l5}));
			c2h_s6 <= 54'(k2_q) * 54'(signed'({1'b0, r4h5}));
			ux_s6  <= sux[68:24];
			uy_s6  <= suy[68:24];
			rc1_s6 <= k1r2_s5 + 44'(ldp_pkg::OneQ28);
			t1_s6  <= t1_s5;
			t2_s6  <= t2_s5;
			x_s6   <= x_s5;
			y_s6   <= y_s5;
		end
		// stage 7
		if (en[6]) begin
			r6_s7   <= sr6[77:28];
			k2r4_s7 <= sk2[74:24];
			tanx_s7 <= (46'(t1_s6) <<< 1) + 46'(ux_s6);
			tany_s7 <= (46'(t2_s6) <<< 1) + 46'(uy_s6);
			rc1_s7  <= rc1_s6;
			x_s7    <= x_s6;
			y_s7    <= y_s6;
		end
		// stage 8: k3 term products
		if (en[7]) begin
			d3l_s8  <= 58'(k3_q) * 58'(signed'({1'b0, r6l7}));
			d3h_s8  <= 58'(k3_q) * 58'(signed'({1'b0, r6h7}));
			rc2_s8  <= 51'(rc1_s7) + k2r4_s7;
			tanx_s8 <= tanx_s7;
			tany_s8 <= tany_s7;
			x_s8    <= x_s7;
			y_s8    <= y_s7;
		end
		// stage 9
		if (en[8]) begin
			k3r6_s9 <= sk3[81:24];
			rc2_s9  <= rc2_s8;
			tanx_s9 <= tanx_s8;
			tany_s9 <= tany_s8;
			x_s9    <= x_s8;
			y_s9    <= y_s8;
		end
		// stage 10: radial factor complete
		if (en[9]) begin
			rc_s10   <= 58'(rc2_s9) + k3r6_s9;
			tanx_s10 <= tanx_s9;
			tany_s10 <= tany_s9;
			x_s10    <= x_s9;
			y_s10    <= y_s9;
		end
		// stage 11: x*rc and y*rc partials
		if (en[10]) begin
			exl_s11  <= 62'(x_s10) * 62'(signed'({1'b0, rcl10}));
			exh_s11  <= 61'(x_s10) * 61'(rch10);
			eyl_s11  <= 62'(y_s10) * 62'(signed'({1'b0, rcl10}));
			eyh_s11  <= 61'(y_s10) * 61'(rch10);
			nex_s11  <= x_s10[31] ^ rc_s10[57];
			ney_s11  <= y_s10[31] ^ rc_s10[57];
			tanx_s11 <= tanx_s10;
			tany_s11 <= tany_s10;
		end
		// stage 12
		if (en[11]) begin
			xd0_s12  <= sxd[88:28];
			yd0_s12  <= syd[88:28];
			tanx_s12 <= tanx_s11;
			tany_s12 <= tany_s11;
		end
		// stage 13: add tangential part
		if (en[12]) begin
			xd_s13 <= xd0_s12 + 61'(tanx_s12);
			yd_s13 <= yd0_s12 + 61'(tany_s12);
		end
		// stage 14: focal scale partials, focal is unsigned
		if (en[13]) begin
			fxl_s14 <= 65'(signed'({1'b0, focal_x_q})) * 65'(signed'({1'b0, xdl13}));
			fxh_s14 <= 63'(signed'({1'b0, focal_x_q})) * 63'(xdh13);
			fyl_s14 <= 65'(signed'({1'b0, focal_y_q})) * 65'(signed'({1'b0, ydl13}));
			fyh_s14 <= 63'(signed'({1'b0, focal_y_q})) * 63'(ydh13);
			nfx_s14 <= xd_s13[60];
			nfy_s14 <= yd_s13[60];
		end
		// stage 15
		if (en[14]) begin
			fmx_s15 <= sfx[92:28];
			fmy_s15 <= sfy[92:28];
		end
		// stage 16: center offset and output clamp
		if (en[15]) begin
			pixel_x_s16 <= ovx ? ldp_pkg::PixMax : (unx ? ldp_pkg::PixMin : vx[31:0]);
			pixel_y_s16 <= ovy ? ldp_pkg::PixMax : (uny ? ldp_pkg::PixMin : vy[31:0]);
			sat_s16     <= ovx || unx || ovy || uny;
		end
	end

	assign pixel_x   = pixel_x_s16;
	assign pixel_y   = pixel_y_s16;
	assign saturated = sat_s16;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for lens_distortion_projection_core
// Streams normalized points through the core under several camera settings,
// predicts each distorted pixel in fixed point and compares every result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint GeoLimit = 64'sh1000_0000_0000_0000;
	localparam int IdxSpan = 16;
	localparam int HoldCycles = 200;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic               sat;
	} pixel_t;

	typedef enum int {CamPlain, CamWild, CamEdge} cam_style_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               point_valid;
	logic               point_stall;
	logic signed [31:0] norm_x;
	logic signed [31:0] norm_y;
	logic               result_valid;
	logic               result_stall;
	logic signed [31:0] pixel_x;
	logic signed [31:0] pixel_y;
	logic               saturated;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [3:0]         cfg_index;
	logic [63:0]        cfg_data;

	logic [63:0] cam_regs [8];
	logic [63:0] next_regs [8];
	pixel_t      expected_pixels [$];
	bit          clip_seen;
	int          error_count = 0;
	bit          send_steady = 0;
	bit          take_steady = 0;
	bit          hold_request = 0;

	lens_distortion_projection_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.saturated    (saturated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp_geo(longint v);
		if (v > GeoLimit) begin
			clip_seen = 1'b1;
			return GeoLimit;
		end
		if (v < -GeoLimit) begin
			clip_seen = 1'b1;
			return -GeoLimit;
		end
		return v;
	endfunction

	function automatic longint add_geo(longint a, longint b);
		return clamp_geo(a + b);
	endfunction

	// exact product, magnitude rounded half away from zero, then clamped
	function automatic longint mul_round(longint a, longint b, int unsigned sh);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] mag;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		mag = {64'd0, ua} * {64'd0, ub};
		mag = (mag + (128'd1 << (sh - 1))) >> sh;
		if (mag > 128'(GeoLimit)) begin
			clip_seen = 1'b1;
			mag = 128'(GeoLimit);
		end
		return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
	endfunction

	function automatic logic signed [31:0] to_pixel(longint f, longint d, longint c);
		longint v;
		v = mul_round(f, d, ldp_pkg::FracQ28) + c;
		if (v > ldp_pkg::PixMax) begin
			clip_seen = 1'b1;
			return ldp_pkg::PixMax;
		end
		if (v < ldp_pkg::PixMin) begin
			clip_seen = 1'b1;
			return ldp_pkg::PixMin;
		end
		return v[31:0];
	endfunction

	function automatic pixel_t project(logic signed [31:0] x32, logic signed [31:0] y32);
		longint x, y, k1, k2, k3, p1, p2;
		longint xx, yy, xy, r2, r4, r6, rc, t, xd, yd;
		pixel_t res;
		clip_seen = 1'b0;
		x = x32;
		y = y32;
		k1 = $signed(cam_regs[ldp_pkg::RegRadialK1][31:0]);
		k2 = $signed(cam_regs[ldp_pkg::RegRadialK2][31:0]);
		k3 = $signed(cam_regs[ldp_pkg::RegRadialK3][31:0]);
		p1 = $signed(cam_regs[ldp_pkg::RegTangential][31:0]);
		p2 = $signed(cam_regs[ldp_pkg::RegTangential][63:32]);

		xx = mul_round(x, x, ldp_pkg::FracQ28);
		yy = mul_round(y, y, ldp_pkg::FracQ28);
		xy = mul_round(x, y, ldp_pkg::FracQ28);
		r2 = add_geo(xx, yy);
		r4 = mul_round(r2, r2, ldp_pkg::FracQ28);
		r6 = mul_round(r4, r2, ldp_pkg::FracQ28);

		rc = add_geo(ldp_pkg::OneQ28, mul_round(k1, r2, ldp_pkg::FracQ24));
		rc = add_geo(rc, mul_round(k2, r4, ldp_pkg::FracQ24));
		rc = add_geo(rc, mul_round(k3, r6, ldp_pkg::FracQ24));

		xd = mul_round(x, rc, ldp_pkg::FracQ28);
		t = mul_round(p1, xy, ldp_pkg::FracQ24);
		xd = add_geo(xd, add_geo(t, t));
		t = add_geo(r2, add_geo(xx, xx));
		xd = add_geo(xd, mul_round(p2, t, ldp_pkg::FracQ24));

		yd = mul_round(y, rc, ldp_pkg::FracQ28);
		t = mul_round(p2, xy, ldp_pkg::FracQ24);
		yd = add_geo(yd, add_geo(t, t));
		t = add_geo(r2, add_geo(yy, yy));
		yd = add_geo(yd, mul_round(p1, t, ldp_pkg::FracQ24));

		res.px = to_pixel(cam_regs[ldp_pkg::RegFocalX][31:0], xd,
			cam_regs[ldp_pkg::RegCenterX][31:0]);
		res.py = to_pixel(cam_regs[ldp_pkg::RegFocalY][31:0], yd,
			cam_regs[ldp_pkg::RegCenterY][31:0]);
		res.sat = clip_seen;
		return res;
	endfunction

	// ---------------------------------------------------------------- random values

	function automatic int srange(int unsigned m);
		return int'($urandom_range(0, 2 * m)) - int'(m);
	endfunction

	function automatic int burst_len();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int sender_gap();
		if (send_steady || $urandom_range(0, 99) < 60)
			return 0;
		return burst_len();
	endfunction

	function automatic logic signed [31:0] pick_coord();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return srange(3 << 27);
		if (pick < 90)
			return $urandom;
		case ($urandom_range(0, 6))
			0: return 32'sh0;
			1: return 32'sh7fff_ffff;
			2: return 32'sh8000_0000;
			3: return 32'sh1;
			4: return -32'sh1;
			5: return 32'sh1000_0000;
			default: return -32'sh1000_0000;
		endcase
	endfunction

	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return 32'h7fff_ffff;
			3: return 32'h8000_0000;
			4: return ldp_pkg::FocalReset;
			default: return $urandom;
		endcase
	endfunction

	// upper halves of the 32-bit registers carry junk that must be dropped
	function automatic void fill_setting(cam_style_t style);
		case (style)
			CamPlain: begin
				next_regs[ldp_pkg::RegFocalX] =
					{$urandom, 32'($urandom_range(200 << 16, 2000 << 16))};
				next_regs[ldp_pkg::RegFocalY] =
					{$urandom, 32'($urandom_range(200 << 16, 2000 << 16))};
				next_regs[ldp_pkg::RegCenterX] =
					{$urandom, 32'($urandom_range(100 << 16, 1000 << 16))};
				next_regs[ldp_pkg::RegCenterY] =
					{$urandom, 32'($urandom_range(100 << 16, 1000 << 16))};
				next_regs[ldp_pkg::RegRadialK1] = {$urandom, 32'(srange(1 << 23))};
				next_regs[ldp_pkg::RegRadialK2] = {$urandom, 32'(srange(1 << 22))};
				next_regs[ldp_pkg::RegRadialK3] = {$urandom, 32'(srange(1 << 21))};
				next_regs[ldp_pkg::RegTangential] =
					{32'(srange(1 << 18)), 32'(srange(1 << 18))};
			end
			CamWild: begin
				foreach (next_regs[i])
					next_regs[i] = {$urandom, $urandom};
			end
			default: begin
				foreach (next_regs[i])
					next_regs[i] = {$urandom, edge_word()};
				next_regs[ldp_pkg::RegTangential] = {edge_word(), edge_word()};
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- channels

	task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ldp_pkg::RegTangential)
			cam_regs[idx] = val;
		else if (idx < ldp_pkg::RegTangential)
			cam_regs[idx] = {32'd0, val[31:0]};
	endtask

	// writes every register, then one index past the map that must be ignored
	task automatic apply_config();
		ldp_pkg::cfg_idx_t r;
		r = r.first();
		do begin
			write_reg(r, next_regs[r]);
			r = r.next();
		end while (r != r.first());
		write_reg(4'($urandom_range(ldp_pkg::RegTangential + 1, IdxSpan - 1)),
			{$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	// valid stays high after acceptance so the next item can follow at once
	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		norm_x <= x;
		norm_y <= y;
		do @(posedge clk); while (point_stall);
		expected_pixels = {expected_pixels, project(x, y)};
	endtask

	task automatic send_random(input int count);
		repeat (count) send_point(pick_coord(), pick_coord());
	endtask

	// a nonempty queue means an item was just taken, so valid is high here
	task automatic wait_drained();
		if (expected_pixels.size() != 0) begin
			point_valid <= 1'b0;
			while (expected_pixels.size() != 0) @(posedge clk);
		end
	endtask

	// receiver: random stall bursts, quiet stretches, and one long hold on request
	initial begin : result_hold
		bit stalling;
		int len;
		result_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				stalling = 1'b1;
				len = HoldCycles;
			end else if (take_steady) begin
				stalling = 1'b0;
				len = 1;
			end else begin
				stalling = ($urandom_range(0, 2) == 0);
				len = stalling ? burst_len() : $urandom_range(1, 6);
			end
			result_stall <= stalling;
			repeat (len) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		pixel_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: result with none pending: %h %h %b",
					$time, pixel_x, pixel_y, saturated);
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_x !== want.px) begin
					$display("%0t: pixel_x expected %h got %h", $time, want.px, pixel_x);
					error_count++;
				end
				if (pixel_y !== want.py) begin
					$display("%0t: pixel_y expected %h got %h", $time, want.py, pixel_y);
					error_count++;
				end
				if (saturated !== want.sat) begin
					$display("%0t: saturated expected %b got %b", $time, want.sat, saturated);
					error_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_reset_defaults();
		send_point(32'sh0, 32'sh0);
		send_point(32'sh1000_0000, 32'sh0);
		send_point(32'sh0, 32'sh1000_0000);
		send_point(-32'sh1000_0000, -32'sh1000_0000);
		send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
		send_point(32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh7fff_ffff, 32'sh8000_0000);
		send_point(32'sh8000_0000, 32'sh7fff_ffff);
		send_point(32'sh1, -32'sh1);
		send_point(32'sh0800_0000, 32'sh0400_0000);
		send_point(32'sh2000_0000, -32'sh2000_0000);
		send_point(32'sh1800_0000, -32'sh0c00_0000);
		wait_drained();
	endtask

	task automatic test_extreme_settings();
		// largest scale, offset and coefficients: terms and outputs clip
		foreach (next_regs[i])
			next_regs[i] = {$urandom, 32'h7fff_ffff};
		next_regs[ldp_pkg::RegFocalX] = {$urandom, 32'hffff_ffff};
		next_regs[ldp_pkg::RegFocalY] = {$urandom, 32'hffff_ffff};
		next_regs[ldp_pkg::RegCenterX] = {$urandom, 32'hffff_ffff};
		next_regs[ldp_pkg::RegCenterY] = {$urandom, 32'hffff_ffff};
		next_regs[ldp_pkg::RegTangential] = 64'h7fff_ffff_7fff_ffff;
		apply_config();
		send_point(32'sh0, 32'sh0);
		send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
		send_point(32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh1000_0000, -32'sh1000_0000);
		send_point(32'sh1, 32'sh1);
		send_point(-32'sh0010_0000, 32'sh0020_0000);
		wait_drained();

		// most negative coefficients, zero and full focal mixed
		foreach (next_regs[i])
			next_regs[i] = {$urandom, 32'h8000_0000};
		next_regs[ldp_pkg::RegFocalX] = 64'h0;
		next_regs[ldp_pkg::RegFocalY] = {$urandom, 32'hffff_ffff};
		next_regs[ldp_pkg::RegCenterX] = {$urandom, 32'hffff_ffff};
		next_regs[ldp_pkg::RegCenterY] = 64'h0;
		next_regs[ldp_pkg::RegTangential] = 64'h8000_0000_8000_0000;
		apply_config();
		send_point(32'sh0, 32'sh0);
		send_point(32'sh7fff_ffff, 32'sh8000_0000);
		send_point(32'sh8000_0000, 32'sh7fff_ffff);
		send_point(32'sh1000_0000, 32'sh1000_0000);
		send_point(-32'sh1, 32'sh1);
		send_point(32'sh0004_0000, -32'sh0008_0000);
		wait_drained();
	endtask

	task automatic test_random_cameras();
		repeat (4) begin
			fill_setting(CamPlain);
			apply_config();
			send_random(100);
			wait_drained();
			send_random(100);
			wait_drained();
		end
	endtask

	task automatic test_odd_settings();
		repeat (3) begin
			fill_setting(CamWild);
			apply_config();
			send_random(80);
			wait_drained();
		end
		repeat (2) begin
			fill_setting(CamEdge);
			apply_config();
			send_random(80);
			wait_drained();
		end
	endtask

	// long receiver hold while points keep coming: the core must stall its input
	task automatic test_backpressure();
		fill_setting(CamPlain);
		apply_config();
		send_steady = 1;
		hold_request = 1;
		wait (hold_request == 0);
		send_random(80);
		send_steady = 0;
		wait_drained();
	endtask

	task automatic test_steady_stream();
		send_steady = 1;
		take_steady = 1;
		send_random(150);
		wait_drained();
		send_steady = 0;
		take_steady = 0;
	endtask

	initial begin : main_flow
		foreach (cam_regs[i])
			cam_regs[i] = 64'd0;
		cam_regs[ldp_pkg::RegFocalX] = ldp_pkg::FocalReset;
		cam_regs[ldp_pkg::RegFocalY] = ldp_pkg::FocalReset;
		arst_n <= 1'b0;
		point_valid <= 1'b0;
		norm_x <= '0;
		norm_y <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_extreme_settings();
		test_random_cameras();
		test_odd_settings();
		test_backpressure();
		test_steady_stream();

		wait_drained();
		repeat (2 * ldp_pkg::NumStages) @(posedge clk);
		if (error_count == 0 && expected_pixels.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
